// File: rtl/mzb_pkg.sv
`timescale 1ns / 1ps

package mzb_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 16;
  localparam int COL_W     = 6;
  localparam int ROW_W     = 4;
  localparam int CELL_W    = COL_W + ROW_W;
  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;

  localparam int GW_W   = 7;
  localparam int GH_W   = 5;
  localparam int CFG_W  = 7;

  localparam logic [GW_W-1:0]  GRID_W_RST    = GW_W'(59);
  localparam logic [GH_W-1:0]  GRID_H_RST    = GH_W'(14);
  localparam logic [COL_W-1:0] START_COL_RST = COL_W'(29);
  localparam logic [ROW_W-1:0] START_ROW_RST = ROW_W'(7);

  typedef enum logic [1:0] {
    CFG_GRID_W,
    CFG_GRID_H,
    CFG_START_COL,
    CFG_START_ROW
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  localparam logic KIND_STEP    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    EV_MOVED,
    EV_RETRY,
    EV_BACKTRACK,
    EV_FINISHED,
    EV_RESTARTED
  } ev_t;

  // grid size in use and clamped start cell
  typedef struct packed {
    logic [GW_W-1:0]  eff_w;
    logic [GH_W-1:0]  eff_h;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
  } geom_t;

endpackage

// File: rtl/mzb_geom.sv
`timescale 1ns / 1ps

module mzb_geom (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [mzb_pkg::CFG_W-1:0]  cfg_wdata,
  output mzb_pkg::geom_t             geom
);

  logic [mzb_pkg::GW_W-1:0]  grid_w_r;
  logic [mzb_pkg::GH_W-1:0]  grid_h_r;
  logic [mzb_pkg::COL_W-1:0] start_col_r;
  logic [mzb_pkg::ROW_W-1:0] start_row_r;
  logic [mzb_pkg::GW_W-1:0]  eff_w;
  logic [mzb_pkg::GH_W-1:0]  eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r    <= mzb_pkg::GRID_W_RST;
      grid_h_r    <= mzb_pkg::GRID_H_RST;
      start_col_r <= mzb_pkg::START_COL_RST;
      start_row_r <= mzb_pkg::START_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        mzb_pkg::CFG_GRID_W:    grid_w_r    <= cfg_wdata[mzb_pkg::GW_W-1:0];
        mzb_pkg::CFG_GRID_H:    grid_h_r    <= cfg_wdata[mzb_pkg::GH_W-1:0];
        mzb_pkg::CFG_START_COL: start_col_r <= cfg_wdata[mzb_pkg::COL_W-1:0];
        mzb_pkg::CFG_START_ROW: start_row_r <= cfg_wdata[mzb_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (grid_w_r == '0) begin
      eff_w = mzb_pkg::GW_W'(1);
    end else if (grid_w_r > mzb_pkg::GW_W'(mzb_pkg::MAX_COLS)) begin
      eff_w = mzb_pkg::GW_W'(mzb_pkg::MAX_COLS);
    end else begin
      eff_w = grid_w_r;
    end
    if (grid_h_r == '0) begin
      eff_h = mzb_pkg::GH_W'(1);
    end else if (grid_h_r > mzb_pkg::GH_W'(mzb_pkg::MAX_ROWS)) begin
      eff_h = mzb_pkg::GH_W'(mzb_pkg::MAX_ROWS);
    end else begin
      eff_h = grid_h_r;
    end
  end

  assign geom.eff_w = eff_w;
  assign geom.eff_h = eff_h;
  // clamp start to last column / row in use
  assign geom.start_col = ({1'b0, start_col_r} < eff_w) ? start_col_r :
                          mzb_pkg::COL_W'(eff_w - mzb_pkg::GW_W'(1));
  assign geom.start_row = ({1'b0, start_row_r} < eff_h) ? start_row_r :
                          mzb_pkg::ROW_W'(eff_h - mzb_pkg::GH_W'(1));

endmodule

// File: rtl/maze_backtracker_step.sv
`timescale 1ns / 1ps
// Depth-first maze walker: one walk step or restart per input word.
// Input channel in_valid/in_ready carries in_kind (0 step, 1 restart) and
// in_direction (0 right, 1 down, 2 left, 3 up). Each word produces exactly
// one result word on out_valid/out_ready: current cell, event code and, for
// a move, the cell and side of the opened wall (zero otherwise).
// Configuration (grid size, start cell) is written through cfg_we/cfg_idx/
// cfg_wdata; the user must write it only while the block is idle (the block
// itself does not enforce this); it then takes effect on the next word.
// A step word is accepted, then three more visited-map reads go through the
// single read port, then the walk decides and loads the result; a backtrack
// adds a stack memory read. A step while finished goes straight to loading
// the result. A restart sweeps the 1024-entry visited map one entry a cycle,
// then loads the result; the next word is accepted once it is loaded.
// The result register is separate from the walk logic: the next word is
// accepted while the previous result still waits. If the receiver stalls,
// the finished walk holds in its load state until the result register frees.
// After reset (rst_n low, synchronous) the block is awaiting restart: step
// words report finished until a restart word arrives.
module maze_backtracker_step #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [mzb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [1:0]                  in_direction,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mzb_pkg::COL_W-1:0]   out_cur_col,
  output logic [mzb_pkg::ROW_W-1:0]   out_cur_row,
  output logic [2:0]                  out_event_res,
  output logic [mzb_pkg::COL_W-1:0]   out_wall_col,
  output logic [mzb_pkg::ROW_W-1:0]   out_wall_row,
  output logic                        out_wall_side
);

  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int COL_W = mzb_pkg::COL_W;
  localparam int ROW_W = mzb_pkg::ROW_W;
  localparam int CELL_W = mzb_pkg::CELL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_PROBE,
    S_DECIDE,
    S_POP,
    S_EMIT
  } state_t;

  mzb_pkg::geom_t geom;

  mzb_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  state_t              state_r, state_nxt;
  logic [1:0]          probe_k_r, probe_k_nxt;
  logic [CELL_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [1:0]          dir_r, dir_nxt;
  logic [2:0]          vis_r, vis_nxt;
  logic [COL_W-1:0]    pos_col_r, pos_col_nxt;
  logic [ROW_W-1:0]    pos_row_r, pos_row_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  mzb_pkg::ev_t        ev_r, ev_nxt;
  logic [COL_W-1:0]    wall_col_r, wall_col_nxt;
  logic [ROW_W-1:0]    wall_row_r, wall_row_nxt;
  logic                wall_side_r, wall_side_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  mzb_pkg::ev_t        out_ev_r, out_ev_nxt;
  logic [COL_W-1:0]    out_wcol_r, out_wcol_nxt;
  logic [ROW_W-1:0]    out_wrow_r, out_wrow_nxt;
  logic                out_wside_r, out_wside_nxt;

  // visited map and path stack
  logic                map_mem [mzb_pkg::MAP_DEPTH];
  logic                map_we;
  logic [CELL_W-1:0]   map_waddr;
  logic                map_wdata;
  logic [CELL_W-1:0]   map_raddr;
  logic                map_rd_q;

  logic [CELL_W-1:0]   stk_mem [STACK_DEPTH];
  logic                stk_we;
  logic [SP_W-1:0]     stk_waddr;
  logic [CELL_W-1:0]   stk_wdata;
  logic [SP_W-1:0]     stk_raddr;
  logic [CELL_W-1:0]   stk_rd_q;

  logic [COL_W-1:0]    nbr_col [4];
  logic [ROW_W-1:0]    nbr_row [4];
  logic                col_in;
  logic                row_in;
  logic [3:0]          ingrid;
  logic [3:0]          vis_all;
  logic [3:0]          open_nb;
  logic [1:0]          rd_k;

  always_comb begin
    nbr_col[mzb_pkg::DIR_RIGHT] = pos_col_r + COL_W'(1);
    nbr_row[mzb_pkg::DIR_RIGHT] = pos_row_r;
    nbr_col[mzb_pkg::DIR_DOWN]  = pos_col_r;
    nbr_row[mzb_pkg::DIR_DOWN]  = pos_row_r + ROW_W'(1);
    nbr_col[mzb_pkg::DIR_LEFT]  = pos_col_r - COL_W'(1);
    nbr_row[mzb_pkg::DIR_LEFT]  = pos_row_r;
    nbr_col[mzb_pkg::DIR_UP]    = pos_col_r;
    nbr_row[mzb_pkg::DIR_UP]    = pos_row_r - ROW_W'(1);

    // the unchanged coordinate must also lie inside a grid that shrank
    col_in = {1'b0, pos_col_r} < geom.eff_w;
    row_in = {1'b0, pos_row_r} < geom.eff_h;
    ingrid[mzb_pkg::DIR_RIGHT] = row_in &&
        (({1'b0, pos_col_r} + mzb_pkg::GW_W'(1)) < geom.eff_w);
    ingrid[mzb_pkg::DIR_DOWN]  = col_in &&
        (({1'b0, pos_row_r} + mzb_pkg::GH_W'(1)) < geom.eff_h);
    // c-1 < w reduces to c <= w
    ingrid[mzb_pkg::DIR_LEFT]  = row_in && (pos_col_r != '0) &&
        ({1'b0, pos_col_r} <= geom.eff_w);
    ingrid[mzb_pkg::DIR_UP]    = col_in && (pos_row_r != '0) &&
        ({1'b0, pos_row_r} <= geom.eff_h);
  end

  assign vis_all = {map_rd_q, vis_r};
  assign open_nb = ingrid & ~vis_all;

  // neighbour 0 is read while idle, the rest one per probe cycle
  assign rd_k      = (state_r == S_PROBE) ? probe_k_r : 2'd0;
  assign map_raddr = {nbr_row[rd_k], nbr_col[rd_k]};
  assign stk_raddr = SP_W'(cnt_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[map_raddr];
  end

  // push and pop never fall in the same cycle; no forwarding needed
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    probe_k_nxt   = probe_k_r;
    clr_addr_nxt  = clr_addr_r;
    dir_nxt       = dir_r;
    vis_nxt       = vis_r;
    pos_col_nxt   = pos_col_r;
    pos_row_nxt   = pos_row_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    ev_nxt        = ev_r;
    wall_col_nxt  = wall_col_r;
    wall_row_nxt  = wall_row_r;
    wall_side_nxt = wall_side_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_ev_nxt    = out_ev_r;
    out_wcol_nxt  = out_wcol_r;
    out_wrow_nxt  = out_wrow_r;
    out_wside_nxt = out_wside_r;

    map_we    = 1'b0;
    map_waddr = {pos_row_r, pos_col_r};
    map_wdata = 1'b1;
    stk_we    = 1'b0;
    stk_waddr = cnt_r[SP_W-1:0];
    stk_wdata = {nbr_row[dir_r], nbr_col[dir_r]};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dir_nxt = in_direction;
          if (in_kind == mzb_pkg::KIND_RESTART) begin
            clr_addr_nxt = '0;
            state_nxt    = S_CLEAR;
          end else if (done_r) begin
            ev_nxt        = mzb_pkg::EV_FINISHED;
            wall_col_nxt  = '0;
            wall_row_nxt  = '0;
            wall_side_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            // mark current cell visited
            map_we      = 1'b1;
            probe_k_nxt = 2'd1;
            state_nxt   = S_PROBE;
          end
        end
      end

      S_CLEAR: begin
        map_we       = 1'b1;
        map_waddr    = clr_addr_r;
        map_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + CELL_W'(1);
        if (clr_addr_r == CELL_W'(mzb_pkg::MAP_DEPTH - 1)) begin
          pos_col_nxt   = geom.start_col;
          pos_row_nxt   = geom.start_row;
          stk_we        = 1'b1;
          stk_waddr     = '0;
          stk_wdata     = {geom.start_row, geom.start_col};
          cnt_nxt       = CNT_W'(1);
          done_nxt      = 1'b0;
          ev_nxt        = mzb_pkg::EV_RESTARTED;
          wall_col_nxt  = '0;
          wall_row_nxt  = '0;
          wall_side_nxt = 1'b0;
          state_nxt     = S_EMIT;
        end
      end

      S_PROBE: begin
        // capture the neighbour read in the previous cycle
        vis_nxt[probe_k_r - 2'd1] = map_rd_q;
        probe_k_nxt = probe_k_r + 2'd1;
        if (probe_k_r == 2'd3) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        wall_col_nxt  = '0;
        wall_row_nxt  = '0;
        wall_side_nxt = 1'b0;
        state_nxt     = S_EMIT;
        if (open_nb != '0) begin
          if (open_nb[dir_r]) begin
            pos_col_nxt = nbr_col[dir_r];
            pos_row_nxt = nbr_row[dir_r];
            // east/south wall of the current cell, or of the new cell
            if (dir_r == mzb_pkg::DIR_RIGHT || dir_r == mzb_pkg::DIR_DOWN) begin
              wall_col_nxt = pos_col_r;
              wall_row_nxt = pos_row_r;
            end else begin
              wall_col_nxt = nbr_col[dir_r];
              wall_row_nxt = nbr_row[dir_r];
            end
            wall_side_nxt = dir_r[0];
            ev_nxt        = mzb_pkg::EV_MOVED;
            // drop the push on a full stack
            if (cnt_r < CNT_W'(STACK_DEPTH)) begin
              stk_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            ev_nxt = mzb_pkg::EV_RETRY;
          end
        end else if (cnt_r != '0) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          ev_nxt    = mzb_pkg::EV_BACKTRACK;
          state_nxt = S_POP;
        end else begin
          done_nxt = 1'b1;
          ev_nxt   = mzb_pkg::EV_FINISHED;
        end
      end

      S_POP: begin
        pos_col_nxt = stk_rd_q[COL_W-1:0];
        pos_row_nxt = stk_rd_q[CELL_W-1:COL_W];
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = pos_col_r;
          out_row_nxt   = pos_row_r;
          out_ev_nxt    = ev_r;
          out_wcol_nxt  = wall_col_r;
          out_wrow_nxt  = wall_row_r;
          out_wside_nxt = wall_side_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_col_r   <= '0;
      pos_row_r   <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_col_r   <= pos_col_nxt;
      pos_row_r   <= pos_row_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    probe_k_r   <= probe_k_nxt;
    clr_addr_r  <= clr_addr_nxt;
    dir_r       <= dir_nxt;
    vis_r       <= vis_nxt;
    ev_r        <= ev_nxt;
    wall_col_r  <= wall_col_nxt;
    wall_row_r  <= wall_row_nxt;
    wall_side_r <= wall_side_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_ev_r    <= out_ev_nxt;
    out_wcol_r  <= out_wcol_nxt;
    out_wrow_r  <= out_wrow_nxt;
    out_wside_r <= out_wside_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cur_col   = out_col_r;
  assign out_cur_row   = out_row_r;
  assign out_event_res = out_ev_r;
  assign out_wall_col  = out_wcol_r;
  assign out_wall_row  = out_wrow_r;
  assign out_wall_side = out_wside_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> $past(cnt_r) == cnt_r + CNT_W'(1))
    else $error("pop without a matching count decrement");

  a_probe_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> !done_r)
    else $error("probing a finished walk");

  a_wall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r != mzb_pkg::EV_MOVED |->
      out_wcol_r == '0 && out_wrow_r == '0 && !out_wside_r)
    else $error("wall fields set on a result other than moved");

endmodule

// File: sim/tb_maze_backtracker_step.sv
`timescale 1ns / 1ps

module tb_maze_backtracker_step;
  import mzb_pkg::*;

  localparam int PATH_DEPTH   = 1024;
  localparam int RANDOM_WORDS = 900;
  localparam int QUIET_WORDS  = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    ev_t              ev;
    logic [COL_W-1:0] wall_col;
    logic [ROW_W-1:0] wall_row;
    logic             wall_side;
  } walk_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [1:0]        in_direction;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [COL_W-1:0]  out_cur_col;
  logic [ROW_W-1:0]  out_cur_row;
  logic [2:0]        out_event_res;
  logic [COL_W-1:0]  out_wall_col;
  logic [ROW_W-1:0]  out_wall_row;
  logic              out_wall_side;

  // walk state mirrored from the block
  bit                visited [MAP_DEPTH];
  logic [CELL_W-1:0] path_cells [PATH_DEPTH];
  int                path_len;
  logic [COL_W-1:0]  at_col;
  logic [ROW_W-1:0]  at_row;
  bit                walk_done;
  logic [GW_W-1:0]   cur_gw;
  logic [GH_W-1:0]   cur_gh;
  logic [COL_W-1:0]  cur_sc;
  logic [ROW_W-1:0]  cur_sr;

  walk_result_t      walk_results_due [$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                total_words = 0;
  int                random_words = 0;
  int                settings_count = 0;
  int                ev_seen [5];
  bit                sender_idle = 1'b0;
  bit                rx_idle;
  int                hold_asks;
  int                hold_served = 0;
  int                hold_left = 0;
  int                stall_left = 0;

  maze_backtracker_step uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_direction  (in_direction),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cur_col   (out_cur_col),
    .out_cur_row   (out_cur_row),
    .out_event_res (out_event_res),
    .out_wall_col  (out_wall_col),
    .out_wall_row  (out_wall_row),
    .out_wall_side (out_wall_side)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int cols_in_use();
    if (cur_gw == 0) return 1;
    if (cur_gw > MAX_COLS) return MAX_COLS;
    return cur_gw;
  endfunction

  function automatic int rows_in_use();
    if (cur_gh == 0) return 1;
    if (cur_gh > MAX_ROWS) return MAX_ROWS;
    return cur_gh;
  endfunction

  function automatic bit spot_free(int c, int r, int w, int h);
    return c >= 0 && c < w && r >= 0 && r < h && !visited[r * MAX_COLS + c];
  endfunction

  // no idling once the run reaches its last stretch
  function automatic bit quiet_tail();
    return random_words >= RANDOM_WORDS - QUIET_WORDS;
  endfunction

  // neighbours of the current cell that the walk may still enter, by direction
  function automatic logic [3:0] free_dirs();
    logic [3:0] m;
    int w, h;
    w = cols_in_use();
    h = rows_in_use();
    m[DIR_RIGHT] = spot_free(int'(at_col) + 1, at_row, w, h);
    m[DIR_DOWN]  = spot_free(at_col, int'(at_row) + 1, w, h);
    m[DIR_LEFT]  = spot_free(int'(at_col) - 1, at_row, w, h);
    m[DIR_UP]    = spot_free(at_col, int'(at_row) - 1, w, h);
    return m;
  endfunction

  function automatic void push_spot();
    // drop the push when the path store is full
    if (path_len < PATH_DEPTH) begin
      path_cells[path_len] = {at_row, at_col};
      path_len++;
    end
  endfunction

  function automatic walk_result_t advance_walk(logic kind, dir_t dir);
    walk_result_t res;
    logic [3:0] m;
    int w, h, c, r;
    logic [CELL_W-1:0] spot;
    res = '0;
    w = cols_in_use();
    h = rows_in_use();
    if (kind == KIND_RESTART) begin
      foreach (visited[i]) visited[i] = 1'b0;
      at_col = (cur_sc < w) ? cur_sc : COL_W'(w - 1);
      at_row = (cur_sr < h) ? cur_sr : ROW_W'(h - 1);
      path_len = 0;
      push_spot();
      walk_done = 1'b0;
      res.ev = EV_RESTARTED;
    end else if (walk_done) begin
      res.ev = EV_FINISHED;
    end else begin
      c = at_col;
      r = at_row;
      visited[r * MAX_COLS + c] = 1'b1;
      m = free_dirs();
      if (m != 0) begin
        if (m[dir]) begin
          case (dir)
            DIR_RIGHT: begin
              res.wall_col = COL_W'(c); res.wall_row = ROW_W'(r);
              res.wall_side = 1'b0; c++;
            end
            DIR_DOWN: begin
              res.wall_col = COL_W'(c); res.wall_row = ROW_W'(r);
              res.wall_side = 1'b1; r++;
            end
            DIR_LEFT: begin
              c--; res.wall_col = COL_W'(c); res.wall_row = ROW_W'(r);
              res.wall_side = 1'b0;
            end
            default: begin
              r--; res.wall_col = COL_W'(c); res.wall_row = ROW_W'(r);
              res.wall_side = 1'b1;
            end
          endcase
          at_col = COL_W'(c);
          at_row = ROW_W'(r);
          push_spot();
          res.ev = EV_MOVED;
        end else begin
          res.ev = EV_RETRY;
        end
      end else if (path_len > 0) begin
        path_len--;
        spot = path_cells[path_len];
        at_col = spot[COL_W-1:0];
        at_row = spot[CELL_W-1:COL_W];
        res.ev = EV_BACKTRACK;
      end else begin
        walk_done = 1'b1;
        res.ev = EV_FINISHED;
      end
    end
    res.col = at_col;
    res.row = at_row;
    ev_seen[res.ev]++;
    return res;
  endfunction

  // mostly head for an open neighbour, otherwise any direction
  function automatic dir_t pick_direction();
    logic [3:0] m;
    int d;
    m = free_dirs();
    d = $urandom_range(0, 3);
    if (!walk_done && m != 0 && $urandom_range(0, 9) < 7) begin
      while (!m[d]) d = $urandom_range(0, 3);
    end
    return dir_t'(d);
  endfunction

  task automatic send_word(logic kind, dir_t dir);
    walk_result_t due;
    if (sender_idle && !quiet_tail() && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_direction <= dir;
    due = advance_walk(kind, dir);
    walk_results_due = {walk_results_due, due};
    total_words++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GRID_W:    cur_gw = val[GW_W-1:0];
      CFG_GRID_H:    cur_gh = val[GH_W-1:0];
      CFG_START_COL: cur_sc = val[COL_W-1:0];
      default:       cur_sr = val[ROW_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [GW_W-1:0] gw, logic [GH_W-1:0] gh,
                              logic [COL_W-1:0] sc, logic [ROW_W-1:0] sr);
    write_reg(CFG_GRID_W, CFG_W'(gw));
    write_reg(CFG_GRID_H, CFG_W'(gh));
    write_reg(CFG_START_COL, CFG_W'(sc));
    write_reg(CFG_START_ROW, CFG_W'(sr));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (walk_results_due.size() == 0) begin
        $error("result word with nothing expected: event %0d at (%0d,%0d)",
               out_event_res, out_cur_col, out_cur_row);
        mismatch_count++;
      end else begin
        want = walk_results_due.pop_front();
        check_field("cur_col", want.col, out_cur_col);
        check_field("cur_row", want.row, out_cur_row);
        check_field("event_res", want.ev, out_event_res);
        check_field("wall_col", want.wall_col, out_wall_col);
        check_field("wall_row", want.wall_row, out_wall_row);
        check_field("wall_side", want.wall_side, out_wall_side);
      end
    end
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0 && !quiet_tail()) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idle && !quiet_tail() && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_step_before_restart();
    send_word(KIND_STEP, DIR_UP);
  endtask

  task automatic test_reset_geometry();
    send_word(KIND_RESTART, DIR_LEFT);
    send_word(KIND_STEP, DIR_RIGHT);
    send_word(KIND_STEP, DIR_DOWN);
    send_word(KIND_STEP, DIR_LEFT);
    send_word(KIND_STEP, DIR_UP);
  endtask

  // zero size counts as one cell; start clamps into it
  task automatic test_single_cell();
    wait_drained();
    set_geometry('0, '0, COL_W'(29), ROW_W'(7));
    send_word(KIND_RESTART, DIR_RIGHT);
    send_word(KIND_STEP, DIR_RIGHT);
    send_word(KIND_STEP, DIR_DOWN);
    send_word(KIND_STEP, DIR_UP);
  endtask

  task automatic test_oversized_grid();
    wait_drained();
    set_geometry('1, '1, '1, '1);
    send_word(KIND_RESTART, DIR_UP);
    send_word(KIND_STEP, DIR_RIGHT);
    send_word(KIND_STEP, DIR_DOWN);
    send_word(KIND_STEP, DIR_LEFT);
    send_word(KIND_STEP, DIR_UP);
  endtask

  // shrink the grid under the walk; position stays outside it
  task automatic test_grid_change_mid_walk();
    wait_drained();
    set_geometry(GW_W'(2), GH_W'(2), '1, '1);
    repeat (4) send_word(KIND_STEP, DIR_LEFT);
  endtask

  task automatic test_backpressure();
    wait_drained();
    set_geometry(GW_W'(8), GH_W'(8), '0, '0);
    send_word(KIND_RESTART, DIR_RIGHT);
    wait_drained();
    sender_idle = 1'b0;
    rx_idle   <= 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (30) send_word(KIND_STEP, pick_direction());
    wait_drained();
  endtask

  task automatic test_random_walks();
    int phase;
    int budget;
    int n;
    int mode;
    logic [GW_W-1:0] gw;
    logic [GH_W-1:0] gh;
    logic [COL_W-1:0] sc;
    logic [ROW_W-1:0] sr;
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      wait_drained();
      case (phase)
        0: begin gw = GW_W'(1); gh = GH_W'(16); sc = '0; sr = '0; end
        1: begin gw = GW_W'(64); gh = GH_W'(1); sc = COL_W'(63); sr = '0; end
        2: begin
          gw = GW_W'(64); gh = GH_W'(16); sc = COL_W'(63); sr = ROW_W'(15);
        end
        3: begin
          gw = GW_W'(5); gh = GH_W'(4); sc = COL_W'(63); sr = ROW_W'(15);
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            gw = GW_W'($urandom_range(0, 127));
            gh = GH_W'($urandom_range(0, 31));
          end else begin
            gw = GW_W'($urandom_range(1, 8));
            gh = GH_W'($urandom_range(1, 6));
          end
          sc = COL_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                           : $urandom_range(0, gw));
          sr = ROW_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                           : $urandom_range(0, gh));
        end
      endcase
      set_geometry(gw, gh, sc, sr);
      // quiet handshakes toward the end of the run
      if (quiet_tail()) begin
        sender_idle = 1'b0;
        rx_idle <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        sender_idle = mode[0];
        rx_idle <= mode[1];
      end
      // now and then keep walking on the new grid
      if (phase == 0 || walk_done || $urandom_range(0, 4) != 0) begin
        send_word(KIND_RESTART, dir_t'($urandom_range(0, 3)));
        random_words++;
      end
      budget = $urandom_range(20, 160);
      for (n = 0; n < budget && random_words < RANDOM_WORDS; n++) begin
        if (walk_done && $urandom_range(0, 2) == 0) break;
        if ($urandom_range(0, 59) == 0)
          send_word(KIND_RESTART, dir_t'($urandom_range(0, 3)));
        else
          send_word(KIND_STEP, pick_direction());
        random_words++;
      end
      phase++;
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_GRID_W;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_STEP;
    in_direction <= DIR_RIGHT;
    rx_idle      <= 1'b1;
    hold_asks    <= 0;
    foreach (visited[i]) visited[i] = 1'b0;
    foreach (ev_seen[i]) ev_seen[i] = 0;
    path_len  = 0;
    at_col    = '0;
    at_row    = '0;
    walk_done = 1'b1;
    cur_gw    = GRID_W_RST;
    cur_gh    = GRID_H_RST;
    cur_sc    = START_COL_RST;
    cur_sr    = START_ROW_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle = 1'b1;

    test_step_before_restart();
    test_reset_geometry();
    test_single_cell();
    test_oversized_grid();
    test_grid_change_mid_walk();
    test_backpressure();
    test_random_walks();

    wait_drained();
    repeat (16) @(posedge clk);
    $display("%0d words over %0d grid settings, random and directed walks",
             total_words, settings_count);
    $display("moved %0d, retry %0d, backtracked %0d, finished %0d, restarted %0d",
             ev_seen[EV_MOVED], ev_seen[EV_RETRY], ev_seen[EV_BACKTRACK],
             ev_seen[EV_FINISHED], ev_seen[EV_RESTARTED]);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
